### sv/assert_macros.svh
// Assertion macros for the RTL of the pixel-row decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_AT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, pre, post, msg) \
	`ASSERT_AT_CLK(label, (pre) |-> (post), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post, msg) \
	`ASSERT_AT_CLK(label, (pre) |=> (post), msg)

`endif

### sv/bprd_pkg.sv
// Package of the bitmap pixel-row decoder: widths, codes and default constants.
`default_nettype none
package bprd_pkg;

	localparam int unsigned DEF_MAX_WIDTH     = 8192;
	localparam int unsigned DEF_PALETTE_DEPTH = 256;

	localparam int unsigned CH_W        = 8;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned COLOR_W     = 24;
	localparam int unsigned IMG_W_BITS  = 14;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	// request opcodes
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	// pixel_format codes
	localparam logic [2:0] FMT_BPP1  = 3'd0;
	localparam logic [2:0] FMT_BPP4  = 3'd1;
	localparam logic [2:0] FMT_BPP8  = 3'd2;
	localparam logic [2:0] FMT_BPP16 = 3'd3;
	localparam logic [2:0] FMT_BPP24 = 3'd4;
	localparam logic [2:0] FMT_BPP32 = 3'd5;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_USE_BITFIELD = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_RED_MASK     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_GREEN_MASK   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_BLUE_MASK    = 3'd5;

	// default channel masks
	localparam logic [WORD_W-1:0] MASK555_R = 32'h0000_7C00;
	localparam logic [WORD_W-1:0] MASK555_G = 32'h0000_03E0;
	localparam logic [WORD_W-1:0] MASK555_B = 32'h0000_001F;
	localparam logic [WORD_W-1:0] MASK888_R = 32'h00FF_0000;
	localparam logic [WORD_W-1:0] MASK888_G = 32'h0000_FF00;
	localparam logic [WORD_W-1:0] MASK888_B = 32'h0000_00FF;

endpackage
`default_nettype wire

### sv/bprd_if.sv
// Handshake channels of the pixel-row decoder: input requests, pixels, register writes.
`default_nettype none
interface bprd_item_if;
	import bprd_pkg::*;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [CH_W-1:0]   palette_slot;
	logic [CH_W-1:0]   palette_blue;
	logic [CH_W-1:0]   palette_green;
	logic [CH_W-1:0]   palette_red;
	logic [CH_W-1:0]   data_byte;
	modport source (output valid, opcode, palette_slot, palette_blue, palette_green,
		palette_red, data_byte, input ready);
	modport sink (input valid, opcode, palette_slot, palette_blue, palette_green,
		palette_red, data_byte, output ready);
endinterface

interface bprd_pixel_if;
	import bprd_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic            row_end;
	logic            last;
	logic            bad_format;
	modport source (output valid, red, green, blue, row_end, last, bad_format, input ready);
	modport sink (input valid, red, green, blue, row_end, last, bad_format, output ready);
endinterface

interface bprd_cfg_if;
	import bprd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

### sv/bprd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bprd_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### sv/bprd_scale.sv
// Iterative channel extractor: aligns a masked field and scales it to 0..255.
`default_nettype none
module bprd_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bprd_pkg::WORD_W-1:0] word,
	input  logic [bprd_pkg::WORD_W-1:0] mask,
	output logic                       done,
	output logic [bprd_pkg::CH_W-1:0]  value
);
	import bprd_pkg::*;

	typedef enum logic [1:0] {SC_IDLE, SC_ALIGN, SC_MUL, SC_DIV} sc_state_t;

	sc_state_t            state_q;
	logic                 done_q;
	logic [2:0]           cnt_q;
	logic [WORD_W-1:0]    m_q;
	logic [WORD_W-1:0]    v_q;
	logic [WORD_W-1:0]    r_q;
	logic [CH_W-1:0]      nl_q;
	logic [CH_W-1:0]      q_q;
	logic [WORD_W+CH_W-1:0] prod;
	logic [WORD_W:0]      trial;
	logic [WORD_W:0]      diff;
	logic                 ge;

	// field * 255 as (field << 8) - field
	assign prod  = {v_q, {CH_W{1'b0}}} - {{CH_W{1'b0}}, v_q};
	assign trial = {r_q, nl_q[CH_W-1]};
	assign diff  = trial - {1'b0, m_q};
	assign ge    = trial >= {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						done_q  <= (mask == '0);
						state_q <= (mask == '0) ? SC_IDLE : SC_ALIGN;
					end
				end
				SC_ALIGN: begin
					if (m_q[0]) begin
						state_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					cnt_q   <= 3'd7;
					state_q <= SC_DIV;
				end
				SC_DIV: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd0) begin
						done_q  <= 1'b1;
						state_q <= SC_IDLE;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	// datapath; the quotient never exceeds 255 since field <= aligned mask
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (start) begin
					m_q <= mask;
					v_q <= word & mask;
					q_q <= '0;
				end
			end
			SC_ALIGN: begin
				if (!m_q[0]) begin
					if (m_q[3:0] == 4'd0) begin
						m_q <= m_q >> 4;
						v_q <= v_q >> 4;
					end else begin
						m_q <= m_q >> 1;
						v_q <= v_q >> 1;
					end
				end
			end
			SC_MUL: begin
				r_q  <= prod[WORD_W+CH_W-1:CH_W];
				nl_q <= prod[CH_W-1:0];
			end
			SC_DIV: begin
				r_q  <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
				nl_q <= {nl_q[CH_W-2:0], 1'b0};
				q_q  <= {q_q[CH_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign value = q_q;
endmodule
`default_nettype wire

### sv/bmp_pixel_row_decoder.sv
// Flow: a palette pixel goes through a palette RAM read, then an output load, and a
// 1 bpp byte repeats this for up to eight pixels; a 24 bpp pixel goes to the output load
// after its last byte; a 16/32 bpp pixel first waits for the iterative scaling unit.
// Bytes that only fill a word or consume padding, and palette writes, keep the block idle.
// Reset: asynchronous; control registers return to defaults and palette valid bits clear at once.
`default_nettype none
`include "assert_macros.svh"
module bmp_pixel_row_decoder #(
	parameter int unsigned MAX_WIDTH     = bprd_pkg::DEF_MAX_WIDTH,
	parameter int unsigned PALETTE_DEPTH = bprd_pkg::DEF_PALETTE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	bprd_item_if.sink     item,
	bprd_pixel_if.source  pixel,
	bprd_cfg_if.sink      cfg
);
	import bprd_pkg::*;

	localparam int unsigned AW = $clog2(PALETTE_DEPTH);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned XW = ((CW > IMG_W_BITS) ? CW : IMG_W_BITS) + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_SCL, ST_PUT} state_t;
	typedef enum logic [1:0] {K_PAL, K_DIR, K_BAD} kind_t;

	state_t                   state_q;
	kind_t                    kind_q;
	logic [2:0]               fmt_q;
	logic                     bitf_q;
	logic [IMG_W_BITS-1:0]    width_q;
	logic [WORD_W-1:0]        rmask_q, gmask_q, bmask_q;
	logic [CW-1:0]            col_q;
	logic [1:0]               phase_q;
	logic [1:0]               pad_q;
	logic [COLOR_W-1:0]       partial_q;
	logic [PALETTE_DEPTH-1:0] valid_q;
	logic [3:0]               cnt_q;
	logic                     ovalid_q;
	logic [CH_W-1:0]          sh_q;
	logic                     hit_q;
	logic [COLOR_W-1:0]       px_q;
	logic [CH_W-1:0]          red_q, green_q, blue_q;
	logic                     row_end_q, last_q, bad_q;

	logic                 acc, is_data, fmt_bad, pal_fmt, need_more, slot_ok;
	logic [2:0]           nbytes;
	logic [WORD_W-1:0]    word_full, word_scl;
	logic [WORD_W-1:0]    rm, gm, bm;
	logic                 scl_start;
	logic [2:0]           scl_done;
	logic [CH_W-1:0]      scl_r, scl_g, scl_b;
	logic [CH_W-1:0]      pal_idx;
	logic                 idx_ok;
	logic [COLOR_W-1:0]   ram_rdata;
	logic [XW-1:0]        eff_w, colp1;
	logic                 row_done, pal_fin, can_load;
	logic [1:0]           pad_new;
	logic [COLOR_W-1:0]   put_color;

	// padding bytes after a row: depends only on width*bpp mod 32
	function automatic logic [1:0] pad_count(input logic [4:0] w5, input logic [2:0] fmt);
		logic [4:0] x5;
		logic [1:0] m3;
		logic [5:0] t;
		m3 = 2'(w5[1:0] + {w5[0], 1'b0});
		case (fmt)
			FMT_BPP1:  x5 = w5;
			FMT_BPP4:  x5 = {w5[2:0], 2'b00};
			FMT_BPP8:  x5 = {w5[1:0], 3'b000};
			FMT_BPP16: x5 = {w5[0], 4'b0000};
			FMT_BPP24: x5 = {m3, 3'b000};
			default:   x5 = 5'd0;
		endcase
		t = {1'b0, x5} + 6'd7;
		return 2'(2'd0 - t[4:3]);
	endfunction

	assign acc      = item.valid && item.ready;
	assign is_data  = (item.opcode == OP_DATA);
	assign fmt_bad  = (fmt_q > FMT_BPP32) ||
		(bitf_q && !(fmt_q inside {FMT_BPP16, FMT_BPP32}));
	assign pal_fmt  = fmt_q inside {FMT_BPP1, FMT_BPP4, FMT_BPP8};
	assign slot_ok  = {1'b0, item.palette_slot} < 9'(PALETTE_DEPTH);

	always_comb begin
		case (fmt_q)
			FMT_BPP16: nbytes = 3'd2;
			FMT_BPP24: nbytes = 3'd3;
			default:   nbytes = 3'd4;
		endcase
	end

	assign need_more = ({1'b0, phase_q} + 3'd1) < nbytes;
	// a stale phase past the pixel size completes the word with what is held
	assign word_full = {8'd0, partial_q} | (WORD_W'(item.data_byte) << {phase_q, 3'b000});
	assign word_scl  = (fmt_q == FMT_BPP16) ? {16'd0, word_full[15:0]} : word_full;

	always_comb begin
		if (bitf_q) begin
			rm = rmask_q;
			gm = gmask_q;
			bm = bmask_q;
		end else if (fmt_q == FMT_BPP16) begin
			rm = MASK555_R;
			gm = MASK555_G;
			bm = MASK555_B;
		end else begin
			rm = MASK888_R;
			gm = MASK888_G;
			bm = MASK888_B;
		end
	end

	assign scl_start = (state_q == ST_IDLE) && acc && is_data && !fmt_bad && (pad_q == 2'd0)
		&& !pal_fmt && !need_more && (fmt_q != FMT_BPP24);

	bprd_scale u_scale_r (.clk(clk), .arst_n(arst_n), .start(scl_start), .word(word_scl),
		.mask(rm), .done(scl_done[0]), .value(scl_r));
	bprd_scale u_scale_g (.clk(clk), .arst_n(arst_n), .start(scl_start), .word(word_scl),
		.mask(gm), .done(scl_done[1]), .value(scl_g));
	bprd_scale u_scale_b (.clk(clk), .arst_n(arst_n), .start(scl_start), .word(word_scl),
		.mask(bm), .done(scl_done[2]), .value(scl_b));

	always_comb begin
		case (fmt_q)
			FMT_BPP1: pal_idx = {7'd0, sh_q[7]};
			FMT_BPP4: pal_idx = {4'd0, sh_q[7:4]};
			default:  pal_idx = sh_q;
		endcase
	end

	assign idx_ok = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);

	// palette is only written from idle and read from ST_RD, so accesses never overlap
	bprd_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_DEPTH)) u_palette (
		.clk   (clk),
		.we    ((state_q == ST_IDLE) && acc && !is_data && slot_ok),
		.waddr (item.palette_slot[AW-1:0]),
		.wdata ({item.palette_red, item.palette_green, item.palette_blue}),
		.re    (state_q == ST_RD),
		.raddr (pal_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		eff_w = XW'(width_q);
		if (eff_w == '0) begin
			eff_w = XW'(1);
		end else if (eff_w > XW'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end
	end

	assign colp1    = XW'(col_q) + XW'(1);
	assign row_done = colp1 >= eff_w;
	assign pad_new  = pad_count(eff_w[4:0], fmt_q);
	assign pal_fin  = row_done || (cnt_q == 4'd1);
	assign can_load = !ovalid_q || pixel.ready;

	always_comb begin
		case (kind_q)
			K_PAL:   put_color = hit_q ? ram_rdata : '0;
			K_DIR:   put_color = px_q;
			default: put_color = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= K_DIR;
			fmt_q     <= FMT_BPP24;
			bitf_q    <= 1'b0;
			width_q   <= IMG_W_BITS'(1);
			rmask_q   <= MASK555_R;
			gmask_q   <= MASK555_G;
			bmask_q   <= MASK555_B;
			col_q     <= '0;
			phase_q   <= '0;
			pad_q     <= '0;
			partial_q <= '0;
			valid_q   <= '0;
			cnt_q     <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_PIXEL_FORMAT: fmt_q   <= cfg.data[2:0];
					REG_USE_BITFIELD: bitf_q  <= cfg.data[0];
					REG_IMAGE_WIDTH:  width_q <= cfg.data[IMG_W_BITS-1:0];
					REG_RED_MASK:     rmask_q <= cfg.data;
					REG_GREEN_MASK:   gmask_q <= cfg.data;
					REG_BLUE_MASK:    bmask_q <= cfg.data;
					default: ;
				endcase
			end
			if ((state_q == ST_PUT) && can_load) begin
				ovalid_q <= 1'b1;
			end else if (pixel.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (!is_data) begin
							if (slot_ok) begin
								valid_q[item.palette_slot[AW-1:0]] <= 1'b1;
							end
						end else if (fmt_bad) begin
							kind_q  <= K_BAD;
							state_q <= ST_PUT;
						end else if (pad_q != 2'd0) begin
							pad_q <= pad_q - 2'd1;
						end else if (pal_fmt) begin
							kind_q  <= K_PAL;
							cnt_q   <= (fmt_q == FMT_BPP1) ? 4'd8 :
								((fmt_q == FMT_BPP4) ? 4'd2 : 4'd1);
							state_q <= ST_RD;
						end else if (need_more) begin
							partial_q <= partial_q |
								COLOR_W'(WORD_W'(item.data_byte) << {phase_q, 3'b000});
							phase_q   <= phase_q + 2'd1;
						end else begin
							partial_q <= '0;
							phase_q   <= '0;
							kind_q    <= K_DIR;
							state_q   <= (fmt_q == FMT_BPP24) ? ST_PUT : ST_SCL;
						end
					end
				end
				ST_RD: state_q <= ST_PUT;
				ST_SCL: begin
					if (scl_done == 3'b111) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (can_load) begin
						if (kind_q != K_BAD) begin
							if (row_done) begin
								col_q <= '0;
								pad_q <= pad_new;
							end else begin
								col_q <= CW'(colp1);
							end
						end
						if ((kind_q == K_PAL) && !pal_fin) begin
							cnt_q   <= cnt_q - 4'd1;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && acc && is_data) begin
			sh_q <= item.data_byte;
			px_q <= word_full[COLOR_W-1:0];
		end
		if (state_q == ST_RD) begin
			hit_q <= idx_ok && valid_q[pal_idx[AW-1:0]];
		end
		if ((state_q == ST_SCL) && (scl_done == 3'b111)) begin
			px_q <= {scl_r, scl_g, scl_b};
		end
		if ((state_q == ST_PUT) && can_load) begin
			red_q     <= put_color[23:16];
			green_q   <= put_color[15:8];
			blue_q    <= put_color[7:0];
			row_end_q <= (kind_q != K_BAD) && row_done;
			last_q    <= (kind_q == K_PAL) ? pal_fin : 1'b1;
			bad_q     <= (kind_q == K_BAD);
			case (fmt_q)
				FMT_BPP1: sh_q <= {sh_q[6:0], 1'b0};
				FMT_BPP4: sh_q <= {sh_q[3:0], 4'd0};
				default:  sh_q <= sh_q;
			endcase
		end
	end

	assign item.ready       = (state_q == ST_IDLE);
	assign cfg.ready        = 1'b1;
	assign pixel.valid      = ovalid_q;
	assign pixel.red        = red_q;
	assign pixel.green      = green_q;
	assign pixel.blue       = blue_q;
	assign pixel.row_end    = row_end_q;
	assign pixel.last       = last_q;
	assign pixel.bad_format = bad_q;

	`ASSERT_NEXT(a_read_then_put, state_q == ST_RD, state_q == ST_PUT,
		"palette read not followed by output load")
	`ASSERT_IMPLIES(a_row_end_is_last, pixel.valid && pixel.row_end, pixel.last,
		"row end pixel not last of its request")
	`ASSERT_IMPLIES(a_bad_is_blank, pixel.valid && pixel.bad_format,
		pixel.last && !pixel.row_end && ((pixel.red | pixel.green | pixel.blue) == 8'd0),
		"format error result not blank")
	`ASSERT_AT_CLK(a_col_range, col_q < CW'(MAX_WIDTH), "pixel column beyond maximum width")
endmodule
`default_nettype wire

### tb/tb.sv
// Testbench of the bitmap pixel-row decoder: directed and random requests, pixel predictor.
module tb;
	import bprd_pkg::*;

	typedef struct packed {
		logic            opcode;
		logic [CH_W-1:0] palette_slot;
		logic [CH_W-1:0] palette_blue;
		logic [CH_W-1:0] palette_green;
		logic [CH_W-1:0] palette_red;
		logic [CH_W-1:0] data_byte;
	} request_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            row_end;
		logic            last;
		logic            bad_format;
	} pixel_t;

	class rgb_scoreboard;
		logic [2:0]         fmt;
		logic               bitfields;
		logic [13:0]        width;
		logic [WORD_W-1:0]  rmask, gmask, bmask;
		logic [COLOR_W-1:0] palette [DEF_PALETTE_DEPTH];
		int unsigned        column, phase, pad;
		logic [23:0]        held;
		pixel_t             pending_pixels [$];
		int                 errors;

		function new();
			fmt = FMT_BPP24;
			bitfields = 1'b0;
			width = 14'd1;
			rmask = MASK555_R;
			gmask = MASK555_G;
			bmask = MASK555_B;
			foreach (palette[i]) palette[i] = '0;
			column = 0;
			phase = 0;
			pad = 0;
			held = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_PIXEL_FORMAT: fmt = val[2:0];
				REG_USE_BITFIELD: bitfields = val[0];
				REG_IMAGE_WIDTH:  width = val[13:0];
				REG_RED_MASK:     rmask = val;
				REG_GREEN_MASK:   gmask = val;
				REG_BLUE_MASK:    bmask = val;
				default: ;
			endcase
		endfunction

		function int unsigned bits_per_pixel();
			case (fmt)
				FMT_BPP1:  return 1;
				FMT_BPP4:  return 4;
				FMT_BPP8:  return 8;
				FMT_BPP16: return 16;
				FMT_BPP24: return 24;
				FMT_BPP32: return 32;
				default:   return 0;
			endcase
		endfunction

		// advance one column; at row end load the padding up to a 4-byte boundary
		function bit step_column(int unsigned bpp);
			int unsigned w, row_bytes;
			w = width;
			if (w == 0) w = 1;
			if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
			if (column + 1 >= w) begin
				row_bytes = (w * bpp + 7) / 8;
				pad = (4 - (row_bytes & 3)) & 3;
				column = 0;
				return 1'b1;
			end
			column++;
			return 1'b0;
		endfunction

		function logic [CH_W-1:0] scale_channel(logic [WORD_W-1:0] word,
			logic [WORD_W-1:0] mask);
			int unsigned s;
			logic [63:0] top, field;
			if (mask == '0) return '0;
			s = 0;
			while (mask[s] == 1'b0) s++;
			top = 64'(mask >> s);
			field = 64'((word & mask) >> s);
			return 8'((field * 64'd255) / top);
		endfunction

		function void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic row_end, logic last, logic bad);
			pixel_t px;
			px = {r, g, b, row_end, last, bad};
			pending_pixels.push_back(px);
		endfunction

		function void note_request(request_t rq);
			int unsigned bpp, per_byte, idx, nbytes;
			logic [COLOR_W-1:0] color;
			logic [WORD_W-1:0] word, rm, gm, bm;
			logic [7:0] r, g, b;
			bit row_done;
			if (rq.opcode == OP_PALETTE) begin
				palette[rq.palette_slot] = {rq.palette_red, rq.palette_green, rq.palette_blue};
				return;
			end
			bpp = bits_per_pixel();
			if (bpp == 0 || (bitfields && bpp != 16 && bpp != 32)) begin
				push_pixel('0, '0, '0, 1'b0, 1'b1, 1'b1);
				return;
			end
			if (pad != 0) begin
				pad--;
				return;
			end
			if (bpp <= 8) begin
				per_byte = 8 / bpp;
				for (int unsigned k = 0; k < per_byte; k++) begin
					idx = (rq.data_byte >> (8 - bpp - k * bpp)) & ((1 << bpp) - 1);
					color = palette[idx];
					row_done = step_column(bpp);
					push_pixel(color[23:16], color[15:8], color[7:0], row_done,
						row_done || (k + 1 == per_byte), 1'b0);
					if (row_done) break;
				end
				return;
			end
			nbytes = bpp / 8;
			if (phase + 1 < nbytes) begin
				held = 24'({8'b0, held} | (32'(rq.data_byte) << (8 * phase)));
				phase++;
				return;
			end
			// a stale phase from a previous format completes the pixel here
			word = {8'b0, held} | (32'(rq.data_byte) << (8 * (phase & 3)));
			held = '0;
			phase = 0;
			if (bpp == 24) begin
				r = word[23:16];
				g = word[15:8];
				b = word[7:0];
			end else begin
				if (bpp == 16) word = word & 32'h0000_FFFF;
				if (bitfields) begin
					rm = rmask;
					gm = gmask;
					bm = bmask;
				end else if (bpp == 16) begin
					rm = MASK555_R;
					gm = MASK555_G;
					bm = MASK555_B;
				end else begin
					rm = MASK888_R;
					gm = MASK888_G;
					bm = MASK888_B;
				end
				r = scale_channel(word, rm);
				g = scale_channel(word, gm);
				b = scale_channel(word, bm);
			end
			row_done = step_column(bpp);
			push_pixel(r, g, b, row_done, 1'b1, 1'b0);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: red=%0d green=%0d blue=%0d row_end=%0d last=%0d %s%0d",
					got.red, got.green, got.blue, got.row_end, got.last, "bad_format=",
					got.bad_format);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				errors++;
			end
			if (got.row_end !== want.row_end) begin
				$error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
			if (got.bad_format !== want.bad_format) begin
				$error("bad_format: expected %0d, got %0d", want.bad_format, got.bad_format);
				errors++;
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;
	rgb_scoreboard sb;

	bprd_item_if  item_ch ();
	bprd_pixel_if pixel_ch ();
	bprd_cfg_if   cfg_ch ();

	bmp_pixel_row_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.pixel  (pixel_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		pixel_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready)
			sb.check_pixel({pixel_ch.red, pixel_ch.green, pixel_ch.blue,
				pixel_ch.row_end, pixel_ch.last, pixel_ch.bad_format});
	end

	initial begin
		#5_000_000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic send_request(input request_t rq);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.opcode        <= rq.opcode;
		item_ch.palette_slot  <= rq.palette_slot;
		item_ch.palette_blue  <= rq.palette_blue;
		item_ch.palette_green <= rq.palette_green;
		item_ch.palette_red   <= rq.palette_red;
		item_ch.data_byte     <= rq.data_byte;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	task automatic send_data(input logic [7:0] data);
		request_t rq;
		rq = {OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data};
		send_request(rq);
	endtask

	task automatic send_palette(input logic [7:0] slot, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		request_t rq;
		rq = {OP_PALETTE, slot, b, g, r, 8'($urandom)};
		send_request(rq);
	endtask

	// hold off requests until every expected pixel is out, then let the block settle
	task automatic wait_results(input int settle);
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	// scaling can still be running after a byte that shows no result yet
	task automatic configure(input logic [2:0] fmt, input logic bf, input logic [13:0] w,
		input logic [31:0] rm, input logic [31:0] gm, input logic [31:0] bm);
		wait_results(30);
		write_reg(REG_PIXEL_FORMAT, {29'b0, fmt});
		write_reg(REG_USE_BITFIELD, {31'b0, bf});
		write_reg(REG_IMAGE_WIDTH, {18'b0, w});
		write_reg(REG_RED_MASK, rm);
		write_reg(REG_GREEN_MASK, gm);
		write_reg(REG_BLUE_MASK, bm);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_mask();
		int unsigned len;
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1 << $urandom_range(0, 31);
			3: begin
				len = $urandom_range(1, 32);
				return 32'(((64'd1 << len) - 1) << $urandom_range(0, 32 - len));
			end
			4: return $urandom();
			default: return 32'h8000_0000;
		endcase
	endfunction

	function automatic void set_idling(input int mode);
		case (mode)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
			default: begin src_idle_pct = 12; snk_stall_pct = 12; end
		endcase
	endfunction

	initial begin
		logic [2:0]  fmt_pick;
		logic        bf_pick;
		logic [13:0] width_pick;
		int unsigned pick;
		request_t    rq;

		sb = new();
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_PALETTE;
		item_ch.palette_slot = '0;
		item_ch.palette_blue = '0;
		item_ch.palette_green = '0;
		item_ch.palette_red = '0;
		item_ch.data_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		pixel_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: 24 bpp, one pixel per row, one padding byte
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'h80);
		send_data(8'h12);
		send_palette(8'd0, 8'h01, 8'h80, 8'hFE);
		send_palette(8'd1, 8'hFF, 8'hFF, 8'hFF);
		send_palette(8'd255, 8'h5A, 8'hA5, 8'h3C);

		// 1 bpp, row ends inside the byte
		configure(FMT_BPP1, 1'b0, 14'd5, MASK555_R, MASK555_G, MASK555_B);
		send_data(8'hA5);
		send_data(8'h00);
		send_data(8'h00);
		send_data(8'h00);
		send_data(8'hFF);

		// 4 bpp, unwritten entry reads its cleared value
		configure(FMT_BPP4, 1'b0, 14'd3, MASK555_R, MASK555_G, MASK555_B);
		send_data(8'h1F);
		send_data(8'hF0);
		send_data(8'h77);
		send_data(8'h77);

		configure(FMT_BPP8, 1'b0, 14'd4, MASK555_R, MASK555_G, MASK555_B);
		send_data(8'hFF);
		send_data(8'h00);
		send_data(8'h01);

		configure(FMT_BPP16, 1'b0, 14'd4, MASK555_R, MASK555_G, MASK555_B);
		send_data(8'hFF);
		send_data(8'h7F);

		// zero width acts as one; all-ones, zero and top-bit masks
		configure(FMT_BPP32, 1'b1, 14'd0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
		send_data(8'hFF);
		send_data(8'h00);
		send_data(8'hAA);
		send_data(8'h80);

		// unsupported combinations
		configure(FMT_BPP24, 1'b1, 14'd16383, 32'h0, 32'h0, 32'h0);
		send_data(8'h55);
		configure(3'd7, 1'b0, 14'd8192, 32'h0, 32'h0, 32'h0);
		send_data(8'hAA);

		for (int p = 0; p < 10; p++) begin
			set_idling(p % 4);
			pick = $urandom_range(0, 13);
			fmt_pick = (pick < 12) ? 3'(pick % 6) : 3'(pick - 6);
			if (fmt_pick == FMT_BPP16 || fmt_pick == FMT_BPP32)
				bf_pick = 1'($urandom_range(0, 1));
			else
				bf_pick = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 9))
				0: width_pick = 14'd0;
				1: width_pick = 14'd8192;
				2: width_pick = 14'd16383;
				3: width_pick = 14'($urandom_range(1, 16383));
				default: width_pick = 14'($urandom_range(1, 12));
			endcase
			configure(fmt_pick, bf_pick, width_pick, random_mask(), random_mask(), random_mask());
			for (int n = 0; n < 15; n++) begin
				if (p == 5 && n == 9) wait_results(0);
				rq.opcode = ($urandom_range(99) < 85) ? OP_DATA : OP_PALETTE;
				rq.palette_slot = 8'($urandom);
				rq.palette_blue = 8'($urandom);
				rq.palette_green = 8'($urandom);
				rq.palette_red = 8'($urandom);
				rq.data_byte = 8'($urandom);
				send_request(rq);
			end
		end

		set_idling(0);
		wait_results(30);
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

### filelist.f
+incdir+sv
sv/bprd_pkg.sv
sv/bprd_if.sv
sv/bprd_ram.sv
sv/bprd_scale.sv
sv/bmp_pixel_row_decoder.sv
tb/tb.sv
